FILE: hdl/assert_macros.svh
// Assertion macros shared by the wait queue RTL.
// Users must have clk and rst (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/wqlc_pkg.sv
// Shared types and constants for the lazy-cancel wait queue.
// No dependencies; imported by every wqlc module.
package wqlc_pkg;

  localparam int TASK_W        = 6;
  localparam int CMD_W         = 2;
  localparam int MAXC_W        = 5;
  localparam int NUM_TASKS_DEF = 64;
  localparam int MAX_BATCH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_TAIL = 2'd0,
    CMD_ADD_HEAD = 2'd1,
    CMD_POP      = 2'd2,
    CMD_REMOVE   = 2'd3
  } cmd_t;

  // Per-task marks kept in the mark memory
  typedef struct packed {
    logic claimed;
    logic waiting;
  } mark_t;

  // One result beat
  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic              found;
    logic              last;
  } result_t;

endpackage

FILE: hdl/wqlc_mark_store.sv
// Claimed/waiting mark memory with a clearing pass after reset.
// Depends on wqlc_pkg.
module wqlc_mark_store
  import wqlc_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int IDX_W     = $clog2(NUM_TASKS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output mark_t            rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  mark_t            wr_data,
  output logic             clr_done
);

  mark_t            mem [NUM_TASKS];
  logic [IDX_W-1:0] clr_idx;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(NUM_TASKS - 1)) begin
        clr_done <= 1'b1;
      end
    end
  end

  // Write port: clearing pass first, then normal writes
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; forward a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: hdl/wqlc_out_reg.sv
// Output register for result beats; frees itself as the sink takes a beat.
// Depends on wqlc_pkg.
module wqlc_out_reg
  import wqlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    free,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res_data
);

  // Room when empty or when the held beat leaves this cycle
  assign free = !res_valid || !res_stall;

  // Hold a beat until taken, load a new one when free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      res_data <= push_data;
    end
  end

endmodule

FILE: hdl/wqlc_engine.sv
// Command sequencer: link memory, head/tail pointers and the pop walk.
// Depends on wqlc_pkg; drives the mark store and the output register.
module wqlc_engine
  import wqlc_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF,
  parameter int IDX_W     = $clog2(NUM_TASKS)
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [TASK_W-1:0] task_id,
  input  logic              still_waiting,
  input  logic [MAXC_W-1:0] batch_max,
  // mark store
  output logic              mk_rd_en,
  output logic [IDX_W-1:0]  mk_rd_addr,
  input  mark_t             mk_rd_data,
  output logic              mk_wr_en,
  output logic [IDX_W-1:0]  mk_wr_addr,
  output mark_t             mk_wr_data,
  input  logic              clr_done,
  // output register
  output logic              push,
  output result_t           push_data,
  input  logic              res_free
);

  localparam int PTR_W = $clog2(NUM_TASKS + 1);
  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam int VIS_W = $clog2(NUM_TASKS + 1);
  localparam logic [PTR_W-1:0] NONE = PTR_W'(NUM_TASKS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_ADD2, S_RM, S_POP, S_FIN, S_RESP
  } state_t;

  state_t            state;
  cmd_t              cmd_q;
  logic [TASK_W-1:0] tid_q;
  logic              still_q;
  logic [CNT_W-1:0]  limit_q;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  result_t           res_q;
  logic              pend_valid;
  logic [TASK_W-1:0] pend_tid;
  logic [CNT_W-1:0]  count;
  logic [VIS_W-1:0]  visits;

  logic [PTR_W-1:0]  link_mem [NUM_TASKS];
  logic [PTR_W-1:0]  link_rd;
  logic              lk_wr_en;
  logic [IDX_W-1:0]  lk_wr_addr;
  logic [PTR_W-1:0]  lk_wr_data;

  logic [CNT_W-1:0]  limit_in;
  logic              tid_ok;
  logic [PTR_W-1:0]  tid_ptr;
  logic              list_empty;
  logic              adv_none;
  logic [PTR_W-1:0]  head_adv;
  logic              found_now;
  logic              need_emit;
  logic              go;
  logic [CNT_W-1:0]  count_inc;
  logic [VIS_W-1:0]  visits_inc;
  logic              cont;

  assign cmd_stall = (state != S_IDLE);

  // Clamp the batch size to 1..MAX_BATCH
  always_comb begin
    if (batch_max == '0) begin
      limit_in = CNT_W'(1);
    end else if (int'(batch_max) > MAX_BATCH) begin
      limit_in = CNT_W'(MAX_BATCH);
    end else begin
      limit_in = CNT_W'(batch_max);
    end
  end

  assign tid_ok     = int'(tid_q) < NUM_TASKS;
  assign tid_ptr    = PTR_W'(tid_q);
  assign list_empty = (head >= NONE) || (tail >= NONE);

  // Pop walk: evaluate the entry at head from the registered read data
  assign adv_none   = (link_rd >= NONE);
  assign head_adv   = adv_none ? NONE : link_rd;
  assign found_now  = !mk_rd_data.claimed;
  assign need_emit  = found_now && pend_valid;
  assign go         = !need_emit || res_free;
  assign count_inc  = count + CNT_W'(found_now);
  assign visits_inc = visits + 1'b1;
  assign cont       = (count_inc < limit_q) && !adv_none && (visits_inc < VIS_W'(NUM_TASKS));

  // Memory port control and result pushes
  always_comb begin
    mk_rd_en   = 1'b0;
    mk_rd_addr = IDX_W'(head);
    mk_wr_en   = 1'b0;
    mk_wr_addr = IDX_W'(tid_q);
    mk_wr_data = '{claimed: 1'b1, waiting: 1'b0};
    lk_wr_en   = 1'b0;
    lk_wr_addr = IDX_W'(tid_q);
    lk_wr_data = NONE;
    push       = 1'b0;
    push_data  = res_q;
    unique case (state)
      S_EXEC: begin
        unique case (cmd_q)
          CMD_POP: begin
            mk_rd_en = (head < NONE);
          end
          CMD_REMOVE: begin
            mk_rd_en   = tid_ok;
            mk_rd_addr = IDX_W'(tid_q);
          end
          CMD_ADD_TAIL, CMD_ADD_HEAD: begin
            mk_wr_en   = tid_ok && still_q;
            mk_wr_data = '{claimed: 1'b0, waiting: 1'b1};
            lk_wr_en   = tid_ok && still_q;
            lk_wr_data = (list_empty || cmd_q == CMD_ADD_TAIL) ? NONE : head;
          end
        endcase
      end
      S_ADD2: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = IDX_W'(tail);
        lk_wr_data = tid_ptr;
      end
      S_RM: begin
        mk_wr_en = mk_rd_data.waiting;
      end
      S_POP: begin
        mk_wr_en   = go && found_now;
        mk_wr_addr = IDX_W'(head);
        mk_rd_en   = go && cont;
        mk_rd_addr = IDX_W'(head_adv);
        push       = go && need_emit;
        push_data  = '{tid: pend_tid, found: 1'b1, last: 1'b0};
      end
      S_FIN: begin
        push = res_free;
        if (pend_valid) begin
          push_data = '{tid: pend_tid, found: 1'b1, last: 1'b1};
        end else begin
          push_data = '{tid: '0, found: 1'b0, last: 1'b1};
        end
      end
      S_RESP: begin
        push = res_free;
      end
      default: begin
      end
    endcase
  end

  // Link memory, read alongside the marks
  always_ff @(posedge clk) begin
    if (lk_wr_en) begin
      link_mem[lk_wr_addr] <= lk_wr_data;
    end
    if (mk_rd_en) begin
      link_rd <= link_mem[mk_rd_addr];
    end
  end

  // Sequencer state, pointers and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      head       <= NONE;
      tail       <= NONE;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q   <= cmd_t'(cmd);
            tid_q   <= task_id;
            still_q <= still_waiting;
            limit_q <= limit_in;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q)
            CMD_POP: begin
              if (head >= NONE) begin
                res_q <= '{tid: '0, found: 1'b0, last: 1'b1};
                state <= S_RESP;
              end else begin
                count      <= '0;
                visits     <= '0;
                pend_valid <= 1'b0;
                state      <= S_POP;
              end
            end
            CMD_REMOVE: begin
              res_q <= '{tid: tid_q, found: 1'b0, last: 1'b1};
              state <= tid_ok ? S_RM : S_RESP;
            end
            CMD_ADD_TAIL, CMD_ADD_HEAD: begin
              if (!tid_ok || !still_q) begin
                res_q <= '{tid: tid_q, found: 1'b0, last: 1'b1};
                state <= S_RESP;
              end else begin
                res_q <= '{tid: tid_q, found: 1'b1, last: 1'b1};
                if (list_empty) begin
                  head  <= tid_ptr;
                  tail  <= tid_ptr;
                  state <= S_RESP;
                end else if (cmd_q == CMD_ADD_TAIL) begin
                  state <= S_ADD2;
                end else begin
                  head  <= tid_ptr;
                  state <= S_RESP;
                end
              end
            end
          endcase
        end
        S_ADD2: begin
          tail  <= tid_ptr;
          state <= S_RESP;
        end
        S_RM: begin
          res_q <= '{tid: tid_q, found: mk_rd_data.waiting, last: 1'b1};
          state <= S_RESP;
        end
        S_POP: begin
          if (go) begin
            visits <= visits_inc;
            head   <= head_adv;
            if (adv_none) begin
              tail <= NONE;
            end
            if (found_now) begin
              pend_valid <= 1'b1;
              pend_tid   <= TASK_W'(head);
              count      <= count_inc;
            end
            if (!cont) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/wait_queue_lazy_cancel.sv
// Channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// command   | cmd_valid, cmd_stall | cmd, task_id, still_waiting, batch_max
// result    | res_valid, res_stall | result_task, found, last
//
// An add runs S_EXEC then S_RESP; a remove adds S_RM and a tail add to a nonempty
// list adds S_ADD2 before S_RESP. A pop runs S_EXEC, S_POP once per entry visited
// (set by the single read port of the mark and link memories), then S_FIN. After
// reset a clearing pass sweeps the mark memory with cmd_stall high. A stalled
// result register holds the sequencer only when it has another beat to hand over.
// Top level of the lazy-cancel wait queue; depends on wqlc_pkg, the wqlc modules
// and assert_macros.svh.
`include "assert_macros.svh"

module wait_queue_lazy_cancel
  import wqlc_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [TASK_W-1:0] task_id,
  input  logic              still_waiting,
  input  logic [MAXC_W-1:0] batch_max,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [TASK_W-1:0] result_task,
  output logic              found,
  output logic              last
);

  localparam int IDX_W = $clog2(NUM_TASKS);

  logic             mk_rd_en;
  logic [IDX_W-1:0] mk_rd_addr;
  mark_t            mk_rd_data;
  logic             mk_wr_en;
  logic [IDX_W-1:0] mk_wr_addr;
  mark_t            mk_wr_data;
  logic             clr_done;
  logic             eng_push;
  result_t          push_data;
  logic             res_free;
  result_t          res_data;

  wqlc_mark_store #(
    .NUM_TASKS (NUM_TASKS),
    .IDX_W     (IDX_W)
  ) u_marks (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (mk_rd_en),
    .rd_addr  (mk_rd_addr),
    .rd_data  (mk_rd_data),
    .wr_en    (mk_wr_en),
    .wr_addr  (mk_wr_addr),
    .wr_data  (mk_wr_data),
    .clr_done (clr_done)
  );

  wqlc_engine #(
    .NUM_TASKS (NUM_TASKS),
    .MAX_BATCH (MAX_BATCH),
    .IDX_W     (IDX_W)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .task_id       (task_id),
    .still_waiting (still_waiting),
    .batch_max     (batch_max),
    .mk_rd_en      (mk_rd_en),
    .mk_rd_addr    (mk_rd_addr),
    .mk_rd_data    (mk_rd_data),
    .mk_wr_en      (mk_wr_en),
    .mk_wr_addr    (mk_wr_addr),
    .mk_wr_data    (mk_wr_data),
    .clr_done      (clr_done),
    .push          (eng_push),
    .push_data     (push_data),
    .res_free      (res_free)
  );

  wqlc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (eng_push),
    .push_data (push_data),
    .free      (res_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign result_task = res_data.tid;
  assign found       = res_data.found;
  assign last        = res_data.last;

  // Checks on the sequencer and result path
  `CHK_IMPLY(a_push_room, eng_push, res_free, "result beat pushed into a full output register")
  `CHK_IMPLY(a_clear_stall, !clr_done, cmd_stall, "command accepted during the clearing pass")
  `CHK_IMPLY(a_open_found, res_valid && !last, found, "non-final result beat without a task")
  `CHK_NEXT(a_accept_busy, cmd_valid && !cmd_stall, cmd_stall, "second command taken while busy")

endmodule
